### src/integer_to_roman_encoder_defines.svh
// Assertion macros for the integer-to-Roman encoder checker.
`ifndef INTEGER_TO_ROMAN_ENCODER_DEFINES_SVH
`define INTEGER_TO_ROMAN_ENCODER_DEFINES_SVH

// Generic clocked assertion, disabled while reset is asserted.
`define ITR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A signal must hold its value on the cycle after cond is seen.
`define ITR_ASSERT_HOLD(lbl, cond, sig, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) cond |=> $stable(sig)) \
    else $error(msg);

`endif

### src/itr_pkg.sv
// Package: types, constants, microcode ROM and symbol tables for the Roman encoder.
`timescale 1ns / 1ps
package itr_pkg;

  localparam int unsigned ValueW  = 12;
  localparam int unsigned CharW   = 7;
  localparam int unsigned DigitW  = 4;
  localparam int unsigned NPlaces = 4;

  localparam logic [ValueW-1:0] MAX_VALUE = 12'd3999;

  // value / 10 == (value * 3277) >> 15, exact for every 12-bit value
  localparam logic [ValueW-1:0] RECIP_TEN = 12'd3277;
  localparam int unsigned       RECIP_SH  = 15;

  localparam logic [CharW-1:0] CH_NONE = 7'd0;
  localparam logic [CharW-1:0] CH_I    = 7'h49;
  localparam logic [CharW-1:0] CH_V    = 7'h56;
  localparam logic [CharW-1:0] CH_X    = 7'h58;
  localparam logic [CharW-1:0] CH_L    = 7'h4C;
  localparam logic [CharW-1:0] CH_C    = 7'h43;
  localparam logic [CharW-1:0] CH_D    = 7'h44;
  localparam logic [CharW-1:0] CH_M    = 7'h4D;

  typedef enum logic [1:0] {
    STEP_WAIT  = 2'd0,
    STEP_DIGIT = 2'd1,
    STEP_EMIT  = 2'd2,
    STEP_ERR   = 2'd3
  } step_t;

  typedef enum logic [1:0] {
    OP_WAIT,
    OP_DIGIT,
    OP_EMIT,
    OP_ERR
  } op_t;

  typedef enum logic [1:0] {
    COND_NONE,
    COND_INVALID,
    COND_DIGITS_DONE,
    COND_FINAL
  } cond_t;

  typedef enum logic [1:0] {
    SYM_ONE,
    SYM_FIVE,
    SYM_TEN
  } sym_kind_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t jump_to;
    step_t next;
  } ctrl_word_t;

  // Datapath status seen by the sequencer.
  typedef struct packed {
    logic in_fire;
    logic slot_free;
    logic invalid;
    logic digits_done;
    logic final_char;
  } status_t;

  function automatic ctrl_word_t ucode_rom(step_t s);
    ctrl_word_t cw;
    case (s)
      STEP_WAIT:  cw = '{op: OP_WAIT,  cond: COND_INVALID,     jump_to: STEP_ERR,
                         next: STEP_DIGIT};
      STEP_DIGIT: cw = '{op: OP_DIGIT, cond: COND_DIGITS_DONE, jump_to: STEP_EMIT,
                         next: STEP_DIGIT};
      STEP_EMIT:  cw = '{op: OP_EMIT,  cond: COND_FINAL,       jump_to: STEP_WAIT,
                         next: STEP_EMIT};
      STEP_ERR:   cw = '{op: OP_ERR,   cond: COND_NONE,        jump_to: STEP_WAIT,
                         next: STEP_WAIT};
      default:    cw = '{op: OP_WAIT,  cond: COND_NONE,        jump_to: STEP_WAIT,
                         next: STEP_WAIT};
    endcase
    return cw;
  endfunction

  // Number of characters a decimal digit produces.
  function automatic logic [2:0] digit_len(logic [DigitW-1:0] d);
    logic [2:0] n;
    case (d)
      4'd1, 4'd5:             n = 3'd1;
      4'd2, 4'd4, 4'd6, 4'd9: n = 3'd2;
      4'd3, 4'd7:             n = 3'd3;
      4'd8:                   n = 3'd4;
      default:                n = 3'd0;
    endcase
    return n;
  endfunction

  // Which symbol of the place the k-th character of digit d uses.
  function automatic sym_kind_t digit_sym(logic [DigitW-1:0] d, logic [1:0] k);
    sym_kind_t s;
    case (d)
      4'd4:                   s = (k == 2'd0) ? SYM_ONE : SYM_FIVE;
      4'd9:                   s = (k == 2'd0) ? SYM_ONE : SYM_TEN;
      4'd5, 4'd6, 4'd7, 4'd8: s = (k == 2'd0) ? SYM_FIVE : SYM_ONE;
      default:                s = SYM_ONE;
    endcase
    return s;
  endfunction

  function automatic logic [CharW-1:0] sym_char(logic [1:0] place, sym_kind_t kind);
    logic [CharW-1:0] c;
    case (kind)
      SYM_ONE: begin
        case (place)
          2'd0:    c = CH_I;
          2'd1:    c = CH_X;
          2'd2:    c = CH_C;
          default: c = CH_M;
        endcase
      end
      SYM_FIVE: begin
        case (place)
          2'd0:    c = CH_V;
          2'd1:    c = CH_L;
          2'd2:    c = CH_D;
          default: c = CH_NONE;
        endcase
      end
      SYM_TEN: begin
        case (place)
          2'd0:    c = CH_X;
          2'd1:    c = CH_C;
          2'd2:    c = CH_M;
          default: c = CH_NONE;
        endcase
      end
      default: c = CH_NONE;
    endcase
    return c;
  endfunction

endpackage

### src/itr_if.sv
// Valid/ready channel interfaces for the Roman encoder input and output.
`timescale 1ns / 1ps
interface itr_in_if;
  logic                        valid;
  logic                        ready;
  logic [itr_pkg::ValueW-1:0]  value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface itr_out_if;
  logic                        valid;
  logic                        ready;
  logic [itr_pkg::CharW-1:0]   symbol_char;
  logic                        last;
  logic                        error;

  modport source (output valid, output symbol_char, output last, output error, input ready);
  modport sink   (input valid, input symbol_char, input last, input error, output ready);
endinterface

### src/itr_seq.sv
// Microcode sequencer: step counter, control ROM and conditional jumps.
`timescale 1ns / 1ps
module itr_seq (
  input  logic             clk,
  input  logic             rst_n,
  input  itr_pkg::status_t status,
  output itr_pkg::op_t     op
);

  itr_pkg::step_t      step_r, step_nxt;
  itr_pkg::ctrl_word_t cw;
  logic                advance;
  logic                cond_true;

  assign cw = itr_pkg::ucode_rom(step_r);
  assign op = cw.op;

  always_comb begin
    case (cw.op)
      itr_pkg::OP_WAIT:  advance = status.in_fire;
      itr_pkg::OP_DIGIT: advance = 1'b1;
      itr_pkg::OP_EMIT:  advance = status.slot_free;
      itr_pkg::OP_ERR:   advance = status.slot_free;
      default:           advance = 1'b0;
    endcase

    case (cw.cond)
      itr_pkg::COND_INVALID:     cond_true = status.invalid;
      itr_pkg::COND_DIGITS_DONE: cond_true = status.digits_done;
      itr_pkg::COND_FINAL:       cond_true = status.final_char;
      default:                   cond_true = 1'b0;
    endcase

    step_nxt = step_r;
    if (advance) begin
      step_nxt = cond_true ? cw.jump_to : cw.next;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= itr_pkg::STEP_WAIT;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

### src/integer_to_roman_encoder.sv
// Top level: integer to Roman numeral encoder, microcoded datapath and output register.
//
// Usage:
// - in_ch carries one 12-bit value per transaction; out_ch carries one ASCII
//   character per transaction (I V X L C D M), most significant place first,
//   with last set on the final character of the numeral.
// - Values 0 and above 3999 give a single transaction with error = 1,
//   last = 1 and symbol_char = 0.
// - One numeral at a time. After acceptance, the digit step splits the value into
//   its four decimal digits (one reciprocal multiply per digit), then the emit step
//   visits the places from thousands down, emitting the characters of each place
//   and stepping over each all-zero place above the lowest nonzero one.
// - Input ready is high only while the sequencer sits in its wait step.
// - A stalled receiver holds the output register; the sequencer waits on it.
// - rst_n (synchronous, active low) returns the sequencer to the wait step and
//   empties the output register.
`timescale 1ns / 1ps
module integer_to_roman_encoder (
  input  logic      clk,
  input  logic      rst_n,
  itr_in_if.sink    in_ch,
  itr_out_if.source out_ch
);

  localparam int unsigned ProdW = 2 * itr_pkg::ValueW;

  itr_pkg::op_t     op;
  itr_pkg::status_t status;

  // datapath registers
  logic [itr_pkg::ValueW-1:0] work_r, work_nxt;
  logic [itr_pkg::DigitW-1:0] digits_r [itr_pkg::NPlaces];
  logic [itr_pkg::DigitW-1:0] digits_nxt [itr_pkg::NPlaces];
  logic [1:0]                 cnt_r, cnt_nxt;
  logic [1:0]                 place_r, place_nxt;
  logic [1:0]                 rep_r, rep_nxt;

  // output register
  logic                       out_valid_r, out_valid_nxt;
  logic [itr_pkg::CharW-1:0]  out_char_r, out_char_nxt;
  logic                       out_last_r, out_last_nxt;
  logic                       out_error_r, out_error_nxt;

  logic                       in_fire;
  logic                       invalid;
  logic                       slot_free;
  logic [ProdW-1:0]           prod;
  logic [itr_pkg::ValueW-1:0] quot;
  logic [itr_pkg::ValueW-1:0] quot_x10;
  logic [itr_pkg::ValueW-1:0] rem_full;
  logic [itr_pkg::DigitW-1:0] cur_digit;
  logic [2:0]                 cur_len;
  logic                       end_of_place;
  logic                       lower_zero;
  logic                       final_char;
  itr_pkg::sym_kind_t         cur_kind;

  assign in_ch.ready = (op == itr_pkg::OP_WAIT);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign invalid     = (in_ch.value == '0) || (in_ch.value > itr_pkg::MAX_VALUE);
  assign slot_free   = !out_valid_r || out_ch.ready;

  // one decimal digit per step: quotient by reciprocal, remainder by subtract
  assign prod     = ProdW'(work_r) * ProdW'(itr_pkg::RECIP_TEN);
  assign quot     = itr_pkg::ValueW'(prod >> itr_pkg::RECIP_SH);
  assign quot_x10 = (quot << 3) + (quot << 1);
  assign rem_full = work_r - quot_x10;

  // current place being emitted
  assign cur_digit    = digits_r[place_r];
  assign cur_len      = itr_pkg::digit_len(cur_digit);
  assign cur_kind     = itr_pkg::digit_sym(cur_digit, rep_r);
  assign end_of_place = ({1'b0, rep_r} + 3'd1) == cur_len;

  // no nonzero digit below the current place
  always_comb begin
    lower_zero = 1'b1;
    for (int i = 0; i < itr_pkg::NPlaces; i++) begin
      if ((2'(i) < place_r) && (digits_r[i] != '0)) begin
        lower_zero = 1'b0;
      end
    end
  end

  assign final_char = ((cur_len != '0) && end_of_place && lower_zero) ||
                      ((cur_len == '0) && (place_r == 2'd0));

  assign status = '{in_fire:     in_fire,
                    slot_free:   slot_free,
                    invalid:     invalid,
                    digits_done: (cnt_r == 2'd3),
                    final_char:  final_char};

  itr_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .op     (op)
  );

  always_comb begin
    work_nxt      = work_r;
    digits_nxt    = digits_r;
    cnt_nxt       = cnt_r;
    place_nxt     = place_r;
    rep_nxt       = rep_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_error_nxt = out_error_r;

    case (op)
      itr_pkg::OP_WAIT: begin
        if (in_fire) begin
          work_nxt  = in_ch.value;
          cnt_nxt   = '0;
          place_nxt = 2'd3;
          rep_nxt   = '0;
          if (invalid) begin
            for (int i = 0; i < itr_pkg::NPlaces; i++) begin
              digits_nxt[i] = '0;
            end
          end
        end
      end
      itr_pkg::OP_DIGIT: begin
        // shift in from the top: the ones digit lands in slot 0 after four steps
        for (int i = 0; i < itr_pkg::NPlaces - 1; i++) begin
          digits_nxt[i] = digits_r[i+1];
        end
        digits_nxt[itr_pkg::NPlaces-1] = rem_full[itr_pkg::DigitW-1:0];
        work_nxt = quot;
        cnt_nxt  = cnt_r + 2'd1;
      end
      itr_pkg::OP_EMIT: begin
        if (slot_free) begin
          if (cur_len == '0) begin
            place_nxt = place_r - 2'd1;
          end else begin
            out_valid_nxt = 1'b1;
            out_char_nxt  = itr_pkg::sym_char(place_r, cur_kind);
            out_last_nxt  = final_char;
            out_error_nxt = 1'b0;
            if (end_of_place) begin
              rep_nxt   = '0;
              place_nxt = place_r - 2'd1;
            end else begin
              rep_nxt = rep_r + 2'd1;
            end
          end
          if (final_char) begin
            place_nxt = '0;
            rep_nxt   = '0;
          end
        end
      end
      itr_pkg::OP_ERR: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = itr_pkg::CH_NONE;
          out_last_nxt  = 1'b1;
          out_error_nxt = 1'b1;
          place_nxt     = '0;
          rep_nxt       = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      place_r     <= '0;
      rep_r       <= '0;
      for (int i = 0; i < itr_pkg::NPlaces; i++) begin
        digits_r[i] <= '0;
      end
    end else begin
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      place_r     <= place_nxt;
      rep_r       <= rep_nxt;
      digits_r    <= digits_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r      <= work_nxt;
    out_char_r  <= out_char_nxt;
    out_last_r  <= out_last_nxt;
    out_error_r <= out_error_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.symbol_char = out_char_r;
  assign out_ch.last        = out_last_r;
  assign out_ch.error       = out_error_r;

endmodule

### src/itr_checker.sv
// Port-level checker for the Roman encoder, bound to the top level.
`timescale 1ns / 1ps
`include "integer_to_roman_encoder_defines.svh"

module itr_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [itr_pkg::CharW-1:0]  symbol_char,
  input logic                       last,
  input logic                       error
);

  logic stalled;
  assign stalled = out_valid && !out_ready;

  `ITR_ASSERT_HOLD(a_out_hold, stalled, symbol_char, "stalled character changed")
  `ITR_ASSERT(a_err_shape, (out_valid && error) |-> (last && (symbol_char == itr_pkg::CH_NONE)), "error transaction must be a lone zero character")
  `ITR_ASSERT(a_char_legal, (out_valid && !error) |-> ((symbol_char == itr_pkg::CH_I) || (symbol_char == itr_pkg::CH_V) || (symbol_char == itr_pkg::CH_X) || (symbol_char == itr_pkg::CH_L) || (symbol_char == itr_pkg::CH_C) || (symbol_char == itr_pkg::CH_D) || (symbol_char == itr_pkg::CH_M)), "character is not a Roman symbol")
  `ITR_ASSERT(a_no_accept_mid, (out_valid && !last) |-> !in_ready, "input taken before the numeral finished")

endmodule

bind integer_to_roman_encoder itr_checker u_itr_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .symbol_char (out_ch.symbol_char),
  .last        (out_ch.last),
  .error       (out_ch.error)
);
